[design/mbfr_pkg.sv]
// Shared constants, codes and helpers for the MSB-first bit-field reader.
package mbfr_pkg;

    localparam int MAX_FIELD_BITS = 32;
    localparam int BUFFER_BITS    = 64;
    localparam int WORD_BITS      = 32;
    localparam int BYTE_BITS      = 8;
    localparam int COUNT_W        = 6;
    localparam int HELD_W         = $clog2(BUFFER_BITS + 1);

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_READ  = 2'd1,
        FN_ALIGN = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // Ones in the low n bits; n equal to BUFFER_BITS gives all ones.
    function automatic logic [BUFFER_BITS-1:0] low_mask(input logic [HELD_W-1:0] n);
        low_mask = ~({BUFFER_BITS{1'b1}} << n);
    endfunction

endpackage

[design/msb_first_bit_field_reader_top.sv]
// MSB-first bit-field reader: bit buffer, input register and result register.
//
// Input channel (in_valid/in_stall): func, word, count. func selects a push of a
// source word, a read of count bits (1 to 32, larger counts saturate to 32), or
// an align that drops the unread rest of the partly used source word.
// Output channel (out_valid/out_stall): one item per input item with field
// (bits read, right-aligned, first bit most significant), status and bits_held.
// Config channel (cfg_valid/cfg_ready/cfg_data): byte_mode, 1 selects 8-bit
// source words; write it only while the block is idle.
// Pipeline: two register stages, the input register, then the shift/mask step
// into the result register. Throughput: 1 item per cycle while the receiver
// does not stall, set by the single shift/mask step on the 64-bit buffer.
// Reset clears the buffer, its count, byte_mode and both valid flags.
// When the receiver stalls, the result register holds; the input register
// takes one more item only if it is empty, then in_stall rises until the result moves.
// Failed reads, zero-width reads and pushes into a full buffer change nothing.
module msb_first_bit_field_reader_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [mbfr_pkg::WORD_BITS-1:0] word,
    input  logic [mbfr_pkg::COUNT_W-1:0]   count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mbfr_pkg::MAX_FIELD_BITS-1:0] field,
    output logic [1:0]                     status,
    output logic [mbfr_pkg::HELD_W-1:0]    bits_held,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);
    import mbfr_pkg::*;

    logic                      byte_mode_reg;
    logic                      s1_vld_reg;
    logic [1:0]                s1_func_reg;
    logic [WORD_BITS-1:0]      s1_word_reg;
    logic [COUNT_W-1:0]        s1_count_reg;
    logic [BUFFER_BITS-1:0]    buf_reg, buf_next;
    logic [HELD_W-1:0]         cnt_reg, cnt_next;
    logic                      out_vld_reg;
    logic [MAX_FIELD_BITS-1:0] field_reg, field_next;
    status_t                   status_reg, status_next;
    logic [HELD_W-1:0]         held_reg;

    logic                      advance;
    logic                      s1_take;
    logic [HELD_W:0]           push_sum;
    logic [COUNT_W-1:0]        rd_cnt;
    logic [HELD_W-1:0]         rd_rest;
    logic [HELD_W-1:0]         al_cnt;
    logic [BUFFER_BITS-1:0]    push_buf;
    logic [BUFFER_BITS-1:0]    rd_shift;
    logic [BUFFER_BITS-1:0]    rd_mask;

    assign advance   = !(out_vld_reg && out_stall);
    assign s1_take   = s1_vld_reg && advance;
    assign in_stall  = s1_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid = out_vld_reg;
    assign field     = field_reg;
    assign status    = status_reg;
    assign bits_held = held_reg;

    always_comb
    begin
        push_sum = {1'b0, cnt_reg} + (byte_mode_reg ? (HELD_W+1)'(BYTE_BITS)
                                                    : (HELD_W+1)'(WORD_BITS));
        push_buf = byte_mode_reg
                 ? ((buf_reg << BYTE_BITS) | BUFFER_BITS'(s1_word_reg[BYTE_BITS-1:0]))
                 : ((buf_reg << WORD_BITS) | BUFFER_BITS'(s1_word_reg));
        rd_cnt   = (s1_count_reg > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS)
                                                             : s1_count_reg;
        rd_rest  = cnt_reg - HELD_W'(rd_cnt);
        rd_shift = buf_reg >> rd_rest;
        rd_mask  = low_mask(HELD_W'(rd_cnt));
        al_cnt   = byte_mode_reg ? {cnt_reg[HELD_W-1:3], 3'b000}
                                 : {cnt_reg[HELD_W-1:5], 5'b00000};

        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        field_next  = '0;
        status_next = ST_OK;

        case (func_t'(s1_func_reg))
            FN_PUSH:
            begin
                if (push_sum > (HELD_W+1)'(BUFFER_BITS))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    buf_next = push_buf;
                    cnt_next = push_sum[HELD_W-1:0];
                end
            end
            FN_READ:
            begin
                if (rd_cnt == '0)
                begin
                    status_next = ST_ZERO;
                end
                else if (HELD_W'(rd_cnt) > cnt_reg)
                begin
                    status_next = ST_SHORT;
                end
                else
                begin
                    field_next = rd_shift[MAX_FIELD_BITS-1:0] & rd_mask[MAX_FIELD_BITS-1:0];
                    cnt_next   = rd_rest;
                    buf_next   = buf_reg & low_mask(rd_rest);
                end
            end
            FN_ALIGN:
            begin
                cnt_next = al_cnt;
                buf_next = buf_reg & low_mask(al_cnt);
            end
            FN_NONE:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_mode_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                byte_mode_reg <= cfg_data;
            end
            if (!in_stall)
            begin
                s1_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
            if (s1_take)
            begin
                buf_reg <= buf_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg  <= func;
            s1_word_reg  <= word;
            s1_count_reg <= count;
        end
        if (s1_take)
        begin
            field_reg  <= field_next;
            status_reg <= status_next;
            held_reg   <= cnt_next;
        end
    end

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= HELD_W'(BUFFER_BITS))
        else $error("bit count above buffer size");

    a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg != ST_OK |-> field_reg == '0)
        else $error("nonzero field on failed item");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && status_reg == ST_FULL
            |-> held_reg > HELD_W'(BUFFER_BITS - WORD_BITS))
        else $error("full status with room in buffer");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_vld_reg && s1_vld_reg)
        else $error("input stalled with free result register");

    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take |=> held_reg == cnt_reg)
        else $error("reported count differs from buffer count");

endmodule
